// ===== hdl/ghue_pkg.sv =====
// Shared types, constants and the sector routing table for the golden hue color generator.
`default_nettype none
package ghue_pkg;

    localparam logic [31:0] GOLDEN_STEP32 = 32'h9E37_79B9;
    localparam logic [16:0] ONE16 = 17'd65536;
    localparam logic [32:0] ONE32 = 33'h1_0000_0000;

    localparam logic REG_SATURATION = 1'b0;
    localparam logic REG_BRIGHTNESS = 1'b1;

    // channel factor codes
    localparam logic [1:0] K_V = 2'd0;   // v
    localparam logic [1:0] K_P = 2'd1;   // v(1-s)
    localparam logic [1:0] K_Q = 2'd2;   // v(1-fs)
    localparam logic [1:0] K_T = 2'd3;   // v(1-(1-f)s)

    localparam logic [1:0] CH_RED = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE = 2'd2;

    typedef struct packed {
        logic [2:0]  sector;
        logic [15:0] frac;
    } ghue_item_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } ghue_back_status_t;

    function automatic logic [1:0] route_code(input logic [2:0] sector, input logic [1:0] ch);
        logic [5:0] row;
        logic [1:0] code;
        begin
            case (sector)
                3'd0: row = {K_V, K_T, K_P};
                3'd1: row = {K_Q, K_V, K_P};
                3'd2: row = {K_P, K_V, K_T};
                3'd3: row = {K_P, K_Q, K_V};
                3'd4: row = {K_T, K_P, K_V};
                default: row = {K_V, K_P, K_Q};
            endcase
            case (ch)
                CH_RED: code = row[5:4];
                CH_GREEN: code = row[3:2];
                default: code = row[1:0];
            endcase
            route_code = code;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ghue_front.sv =====
// Front end: hue phase register, golden-step advance or load, sector and fraction split.
`default_nettype none
module ghue_front #(
    parameter int HUE_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                cmd,
    input  wire logic [31:0]         hue_load,
    input  wire logic                q_full,
    output logic                     in_stall,
    output logic                     push,
    output ghue_pkg::ghue_item_t     item
);
    import ghue_pkg::*;

    localparam logic [HUE_BITS-1:0] STEP = HUE_BITS'(GOLDEN_STEP32 >> (32 - HUE_BITS));

    logic [HUE_BITS-1:0] hue_phase_reg;
    logic [HUE_BITS-1:0] hue_phase_next;
    logic [HUE_BITS+2:0] h6;

    assign in_stall = q_full;
    assign push = in_valid && !q_full;

    always_comb
    begin
        if (cmd)
        begin
            hue_phase_next = hue_load[31 -: HUE_BITS];
        end
        else
        begin
            hue_phase_next = hue_phase_reg + STEP;
        end
        h6 = {1'b0, hue_phase_next, 2'b00} + {2'b00, hue_phase_next, 1'b0};
        item.sector = h6[HUE_BITS+2:HUE_BITS];
        item.frac = h6[HUE_BITS-1 -: 16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_phase_reg <= '0;
        end
        else if (push)
        begin
            hue_phase_reg <= hue_phase_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ghue_queue.sv =====
// Two-entry queue between the front end and the conversion back end.
`default_nettype none
module ghue_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ghue_pkg::ghue_item_t push_item,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      not_empty,
    output logic [1:0]                level,
    output ghue_pkg::ghue_item_t      head
);
    import ghue_pkg::*;

    ghue_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign level = count_reg;
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ghue_back.sv =====
// Back end: HSV to RGB conversion over four steps on one shared multiplier, output register.
`default_nettype none
module ghue_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_not_empty,
    input  wire ghue_pkg::ghue_item_t  q_head,
    input  wire logic [16:0]           sat,
    input  wire logic [16:0]           val,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [7:0]                 red,
    output logic [7:0]                 green,
    output logic [7:0]                 blue,
    output ghue_pkg::ghue_back_status_t status
);
    import ghue_pkg::*;

    logic       busy_reg;
    logic [1:0] step_reg;
    ghue_item_t item_reg;
    logic [32:0] fs_reg;
    logic [7:0] red_part_reg;
    logic [7:0] green_part_reg;
    logic       out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    logic        out_free;
    logic        finish;
    logic        pop;
    logic [16:0] one_minus_s;
    logic [32:0] k_sel;
    logic [16:0] mul_a;
    logic [32:0] mul_b;
    logic [49:0] prod;
    logic [7:0]  chan;

    assign out_free = !out_valid_reg || !out_stall;
    assign finish = busy_reg && (step_reg == 2'd3) && out_free;
    assign pop = q_not_empty && (!busy_reg || finish);

    always_comb
    begin
        one_minus_s = ONE16 - sat;
        case (route_code(item_reg.sector, step_reg - 2'd1))
            K_V: k_sel = ONE32;
            K_P: k_sel = {one_minus_s, 16'h0000};
            K_Q: k_sel = ONE32 - fs_reg;
            K_T: k_sel = ONE32 - ({sat, 16'h0000} - fs_reg);
            default: k_sel = ONE32;
        endcase
        if (step_reg == 2'd0)
        begin
            mul_a = {1'b0, item_reg.frac};
            mul_b = {16'h0000, sat};
        end
        else
        begin
            mul_a = val;
            mul_b = k_sel;
        end
        prod = 50'(mul_a) * 50'(mul_b);
        chan = (prod[49:40] > 10'd255) ? 8'd255 : prod[47:40];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_head;
        end
        if (busy_reg)
        begin
            case (step_reg)
                2'd0: fs_reg <= prod[32:0];
                2'd1: red_part_reg <= chan;
                2'd2: green_part_reg <= chan;
                default: fs_reg <= fs_reg;
            endcase
        end
        if (finish)
        begin
            red_reg <= red_part_reg;
            green_reg <= green_part_reg;
            blue_reg <= chan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && step_reg != 2'd3)
            begin
                step_reg <= step_reg + 2'd1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;
    assign status = '{busy: busy_reg, pop: pop};

endmodule
`default_nettype wire

// ===== hdl/golden_hue_hsv_to_rgb.sv =====
// Top level of the golden-ratio hue color generator.
// Each accepted beat advances the hue phase by the golden-ratio fraction (cmd 0) or loads it
// from hue_load (cmd 1), then converts hue, saturation and brightness to 8-bit RGB. The front
// end takes one beat per cycle into a two-entry queue unless it is full; the back end
// works each color on one multiplier shared by the f*s product and the three channel products,
// and takes the next beat only as it finishes. From idle, out_valid rises after a beat passes
// the queue, item register and steps. A finished color waits in the output register while
// the next is worked on. Write saturation and brightness only while no beat is in flight.
`default_nettype none
module golden_hue_hsv_to_rgb #(
    parameter int HUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] hue_load,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue
);
    import ghue_pkg::*;

    logic [16:0] saturation_reg;
    logic [16:0] brightness_reg;
    logic [16:0] sat_clamped;
    logic [16:0] val_clamped;

    logic              push;
    logic              q_full;
    logic              q_not_empty;
    logic [1:0]        q_level;
    ghue_item_t        front_item;
    ghue_item_t        q_head;
    ghue_back_status_t back_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg <= 17'd32768;
            brightness_reg <= 17'd62259;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SATURATION: saturation_reg <= cfg_data;
                REG_BRIGHTNESS: brightness_reg <= cfg_data;
                default: saturation_reg <= saturation_reg;
            endcase
        end
    end

    assign sat_clamped = (saturation_reg > ONE16) ? ONE16 : saturation_reg;
    assign val_clamped = (brightness_reg > ONE16) ? ONE16 : brightness_reg;

    ghue_front #(
        .HUE_BITS(HUE_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .cmd(cmd),
        .hue_load(hue_load),
        .q_full(q_full),
        .in_stall(in_stall),
        .push(push),
        .item(front_item)
    );

    ghue_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_item(front_item),
        .pop(back_status.pop),
        .full(q_full),
        .not_empty(q_not_empty),
        .level(q_level),
        .head(q_head)
    );

    ghue_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_not_empty(q_not_empty),
        .q_head(q_head),
        .sat(sat_clamped),
        .val(val_clamped),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .red(red),
        .green(green),
        .blue(blue),
        .status(back_status)
    );

`ifndef ASSERT_OFF
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        q_level != 2'd3)
        else $error("queue level overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pop |-> q_not_empty)
        else $error("back end popped an empty queue");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pop |=> back_status.busy)
        else $error("back end idle after taking a beat");

    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_status.busy))
        else $error("output beat without conversion");
`endif

endmodule
`default_nettype wire

// ===== tb/ghue_checker.sv =====
// Color checker for the golden hue generator: tracks hue and levels, predicts and compares beats.
module ghue_checker #(
    parameter int HUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] hue_load,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output int               mismatches,
    output int               colors_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ghue_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    localparam logic [63:0] HUE_MASK = (64'd1 << HUE_BITS) - 64'd1;
    localparam logic [63:0] TURN32 = 64'd1 << 32;

    // factor feeding red, green, blue in each hue sector
    localparam logic [1:0] SECTOR_MAP [6][3] = '{
        '{K_V, K_T, K_P},
        '{K_Q, K_V, K_P},
        '{K_P, K_V, K_T},
        '{K_P, K_Q, K_V},
        '{K_T, K_P, K_V},
        '{K_V, K_P, K_Q}
    };

    logic [31:0] hue_acc;
    logic [16:0] sat_level;
    logic [16:0] val_level;
    color_t      colors_due[$];

    function automatic logic [7:0] scale_channel(input logic [63:0] v, input logic [63:0] k);
        logic [63:0] c;
        c = (v * k) >> 40;
        return (c > 64'd255) ? 8'd255 : c[7:0];
    endfunction

    function automatic color_t predict_color(input logic [31:0] hue, input logic [16:0] sat,
                                             input logic [16:0] val);
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] h6;
        logic [63:0] sector;
        logic [63:0] f;
        logic [63:0] k [4];
        color_t      c;
        s = (sat > ONE16) ? 64'(ONE16) : 64'(sat);
        v = (val > ONE16) ? 64'(ONE16) : 64'(val);
        h6 = 64'(hue) * 64'd6;
        sector = h6 >> HUE_BITS;
        if (sector > 64'd5)
        begin
            sector = 64'd5;
        end
        f = (h6 & HUE_MASK) >> (HUE_BITS - 16);
        k[K_V] = TURN32;
        k[K_P] = (64'(ONE16) - s) << 16;
        k[K_Q] = TURN32 - f * s;
        k[K_T] = TURN32 - (64'(ONE16) - f) * s;
        c.red = scale_channel(v, k[SECTOR_MAP[sector[2:0]][0]]);
        c.green = scale_channel(v, k[SECTOR_MAP[sector[2:0]][1]]);
        c.blue = scale_channel(v, k[SECTOR_MAP[sector[2:0]][2]]);
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ERROR: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    initial
    begin
        mismatches = 0;
        colors_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        if (!rst_n)
        begin
            hue_acc = '0;
            sat_level = 17'd32768;
            val_level = 17'd62259;
            colors_due.delete();
            colors_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SATURATION)
                begin
                    sat_level = cfg_data;
                end
                else
                begin
                    val_level = cfg_data;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (colors_due.size() == 0)
                begin
                    report_mismatch($sformatf("color beat %0d/%0d/%0d with none due",
                                              red, green, blue));
                end
                else
                begin
                    want = colors_due.pop_front();
                    check_field("red", red, want.red);
                    check_field("green", green, want.green);
                    check_field("blue", blue, want.blue);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (cmd)
                begin
                    hue_acc = 32'((64'(hue_load) >> (32 - HUE_BITS)) & HUE_MASK);
                end
                else
                begin
                    hue_acc = 32'((64'(hue_acc) + (64'(GOLDEN_STEP32) >> (32 - HUE_BITS)))
                                  & HUE_MASK);
                end
                colors_due.push_back(predict_color(hue_acc, sat_level, val_level));
            end
            colors_pending = colors_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the golden hue generator: clock, reset, stimulus, stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ghue_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [31:0] hue_load;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    int          mismatches;
    int          colors_pending;
    int          send_idle;
    int          recv_idle;

    golden_hue_hsv_to_rgb uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .hue_load(hue_load),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red(red),
        .green(green),
        .blue(blue)
    );

    ghue_checker color_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .hue_load(hue_load),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .mismatches(mismatches),
        .colors_pending(colors_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // one beat; returns just after the edge that took it
    task automatic send_hue(input logic c, input logic [31:0] h);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        hue_load <= h;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (colors_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_levels(input logic [16:0] sat, input logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= REG_SATURATION;
        cfg_data <= sat;
        @(posedge clk);
        cfg_index <= REG_BRIGHTNESS;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [16:0] pick_level();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [31:0] pick_hue();
        if ($urandom_range(3) == 0)
        begin
            return 32'($urandom_range(5)) * 32'h2AAA_AAAB + 32'($urandom_range(2)) - 32'd1;
        end
        return $urandom();
    endfunction

    initial
    begin
        logic [16:0] sat_pick;
        logic [16:0] val_pick;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SATURATION;
        cfg_data <= '0;
        in_valid <= 1'b0;
        cmd <= 1'b0;
        hue_load <= '0;
        out_stall <= 1'b0;
        send_idle = 0;
        recv_idle = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sector edges at reset levels, then advances across the wrap
        send_hue(1'b1, 32'h0000_0000);
        send_hue(1'b1, 32'h2AAA_AAAA);
        send_hue(1'b1, 32'h2AAA_AAAB);
        send_hue(1'b1, 32'h5555_5555);
        send_hue(1'b1, 32'h5555_5556);
        send_hue(1'b1, 32'h8000_0000);
        send_hue(1'b1, 32'hAAAA_AAAA);
        send_hue(1'b1, 32'hAAAA_AAAB);
        send_hue(1'b1, 32'hD555_5555);
        send_hue(1'b1, 32'hD555_5556);
        send_hue(1'b1, 32'hFFFF_FFFF);
        send_hue(1'b0, 32'hFFFF_FFFF);
        send_hue(1'b0, 32'h0000_0000);
        send_hue(1'b0, 32'h5A5A_A5A5);
        wait_idle();
        set_levels(17'd65536, 17'd65536);
        send_hue(1'b1, 32'h0000_0000);
        send_hue(1'b1, 32'h1555_5555);
        send_hue(1'b0, 32'hA5A5_5A5A);
        send_hue(1'b0, 32'h0000_0000);
        wait_idle();
        set_levels(17'h1FFFF, 17'h1FFFF);
        send_hue(1'b1, 32'h4000_0000);
        send_hue(1'b0, 32'hFFFF_FFFF);
        wait_idle();
        set_levels(17'd0, 17'd0);
        send_hue(1'b1, 32'h9E37_79B9);
        send_hue(1'b0, 32'h0000_0000);

        for (int mode = 0; mode < 3; mode++)
        begin
            wait_idle();
            case (mode)
                0:
                begin
                    send_idle = 20;
                    recv_idle = 52;
                end
                1:
                begin
                    send_idle = 52;
                    recv_idle = 20;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++)
            begin
                wait_idle();
                if (blk == 0)
                begin
                    sat_pick = (mode == 1) ? 17'd65536 : ((mode == 0) ? 17'd0 : 17'h1FFFF);
                    val_pick = (mode == 1) ? 17'd0 : 17'd65536;
                end
                else
                begin
                    sat_pick = pick_level();
                    val_pick = pick_level();
                end
                set_levels(sat_pick, val_pick);
                repeat (50)
                begin
                    send_hue($urandom_range(99) < 30, pick_hue());
                end
            end
        end

        wait_idle();
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ghue_pkg.sv
hdl/ghue_front.sv
hdl/ghue_queue.sv
hdl/ghue_back.sv
hdl/golden_hue_hsv_to_rgb.sv
tb/ghue_checker.sv
tb/tb.sv
